// ===== src/arpc_pkg.sv =====
// types and codes shared by the arp cache table modules
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  // command field of an input beat
  typedef enum logic [0:0] {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  // status field of a result beat
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESP
  } back_state_e;

  // classified request as it sits in the queue
  typedef struct packed {
    cmd_e        cmd;
    logic        zero_key;
    logic [31:0] ip_key;
    logic [47:0] mac;
  } req_t;

endpackage

`default_nettype wire

// ===== src/arp_cache_table_top.sv =====
// top level of the arp cache table: front queue and back scan engine
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o   | cmd_i, ip_key_i, mac_in_i
//  out     | output    | out_valid_o / out_ready_i | status_o, mac_out_o
//
// once an item is at the queue head, the scan reads one filled slot per cycle:
// the key store has one read port. the front queue holds two beats, so input
// keeps flowing while a scan runs or a result waits, until both entries are full.
// reset clears the fill count and control only; the stores are never cleared
// and slots at or past the fill count are not compared.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table_top
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] ip_key_i,
  input  wire logic [47:0] mac_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [47:0]      mac_out_o
);

  logic q_valid;
  logic q_ready;
  req_t q_req;

  // accept and classify
  arpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .ip_key_i   (ip_key_i),
    .mac_in_i   (mac_in_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  // scan, update and respond
  arpc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .mac_out_o   (mac_out_o)
  );

endmodule

`default_nettype wire

// ===== src/arpc_front.sv =====
// front end: accepts input beats, classifies them, holds them in a two-entry queue
`timescale 1ns / 1ps
`default_nettype none

module arpc_front
  import arpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] ip_key_i,
  input  wire logic [47:0] mac_in_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output req_t             q_req_o
);

  req_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  req_t       new_req;

  // classify the incoming beat
  always_comb begin
    new_req.cmd      = cmd_e'(cmd_i);
    new_req.zero_key = (ip_key_i == 32'd0);
    new_req.ip_key   = ip_key_i;
    new_req.mac      = mac_in_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_req_o    = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

`default_nettype wire

// ===== src/arpc_back.sv =====
// back end: scans the key store, applies updates and inserts, holds the result beat
`timescale 1ns / 1ps
`default_nettype none

module arpc_back
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire req_t        q_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [47:0]      mac_out_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // key and mac stores, no reset
  logic [31:0] key_mem [TABLE_DEPTH];
  logic [47:0] mac_mem [TABLE_DEPTH];

  back_state_e   state_q, state_d;
  req_t          cur_q, cur_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CW-1:0] cmp_cnt_q, cmp_cnt_d;
  logic          cmp_valid_q, cmp_valid_d;
  logic [31:0]   key_rd_q;
  logic [47:0]   mac_rd_q;
  status_e       res_status_q, res_status_d;
  logic [47:0]   res_mac_q, res_mac_d;
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q;
  logic [47:0]   out_mac_q;

  logic          scan_hit, last_cmp, scan_done, out_load;
  logic          key_we, mac_we;
  logic [IW-1:0] wr_addr;

  // scan status
  assign scan_hit  = cmp_valid_q && !cur_q.zero_key && (key_rd_q == cur_q.ip_key);
  assign last_cmp  = cmp_valid_q && ((cmp_cnt_q + CW'(1)) == fill_q);
  assign scan_done = (state_q == BK_SCAN) &&
                     (cur_q.zero_key || (fill_q == '0) || scan_hit || last_cmp);
  assign out_load  = (state_q == BK_RESP) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_SCAN;
      BK_SCAN: if (scan_done) state_d = BK_RESP;
      BK_RESP: if (out_load)  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    q_ready_o    = (state_q == BK_IDLE);
    cur_d        = cur_q;
    fill_d       = fill_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_cnt_d    = rd_cnt_q;
    cmp_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_mac_d    = res_mac_q;
    key_we       = 1'b0;
    mac_we       = 1'b0;
    wr_addr      = fill_q[IW-1:0];
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          cur_d    = q_req_i;
          rd_cnt_d = '0;
        end
      end
      BK_SCAN: begin
        if (!scan_done) begin
          // issue the next slot read; its compare follows in the next cycle
          cmp_valid_d = (rd_cnt_q < fill_q);
          if (rd_cnt_q < fill_q) begin
            rd_cnt_d = rd_cnt_q + CW'(1);
          end
        end else if (cur_q.cmd == CMD_LOOKUP) begin
          res_status_d = scan_hit ? ST_HIT : ST_MISS;
          res_mac_d    = scan_hit ? mac_rd_q : 48'd0;
        end else begin
          res_mac_d = 48'd0;
          priority if (cur_q.zero_key) begin
            res_status_d = ST_DROPPED;
          end else if (scan_hit) begin
            res_status_d = ST_UPDATED;
            mac_we       = 1'b1;
            wr_addr      = cmp_cnt_q[IW-1:0];
          end else if (fill_q < DepthC) begin
            res_status_d = ST_INSERTED;
            key_we       = 1'b1;
            mac_we       = 1'b1;
            fill_d       = fill_q + CW'(1);
          end else begin
            res_status_d = ST_DROPPED;
          end
        end
      end
      BK_RESP: ;
      default: ;
    endcase
  end

  // result register toward the output channel
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      fill_q      <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    rd_cnt_q     <= rd_cnt_d;
    cmp_cnt_q    <= cmp_cnt_d;
    res_status_q <= res_status_d;
    res_mac_q    <= res_mac_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_mac_q    <= res_mac_q;
    end
  end

  // store access: one write port, registered reads at the scan address
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= cur_q.ip_key;
    end
    if (mac_we) begin
      mac_mem[wr_addr] <= cur_q.mac;
    end
    key_rd_q <= key_mem[rd_cnt_q[IW-1:0]];
    mac_rd_q <= mac_mem[rd_cnt_q[IW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign mac_out_o   = out_mac_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC)
    else $error("fill count beyond table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> (fill_q == $past(fill_q) + CW'(1)))
    else $error("insert did not advance fill count");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_valid_q |-> (state_q == BK_SCAN) && (cmp_cnt_q < fill_q))
    else $error("compare outside a scan or past filled slots");

  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == BK_IDLE))
    else $error("result load did not present a beat");
`endif

endmodule

`default_nettype wire
